// File: hdl/vrd_pkg.sv
// Shared constants, types, microcode and glyph table for the radix digit writer.
`default_nettype none

package vrd_pkg;

    localparam int WHOLE_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 4;

    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int PROD_W  = FRAC_BITS + BASE_W;

    localparam int STACK_DEPTH = WHOLE_BITS;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_MAX     = (WHOLE_BITS > FRAC_DIGITS) ? WHOLE_BITS : FRAC_DIGITS;
    localparam int CNT_W       = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_BASE = 1'b0;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

    localparam logic [CHAR_W-1:0] ASCII_POINT = CHAR_W'(46);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] ASCII_SPACE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_A     = CHAR_W'(65);

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_MINUS = 4'd2;
    localparam logic [OP_W-1:0] OP_DINIT = 4'd3;
    localparam logic [OP_W-1:0] OP_DSTEP = 4'd4;
    localparam logic [OP_W-1:0] OP_PUSH  = 4'd5;
    localparam logic [OP_W-1:0] OP_POP   = 4'd6;
    localparam logic [OP_W-1:0] OP_POINT = 4'd7;
    localparam logic [OP_W-1:0] OP_FRAC  = 4'd8;
    localparam logic [OP_W-1:0] OP_SPACE = 4'd9;

    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NONE   = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS = 3'd1;
    localparam logic [COND_W-1:0] COND_CNT    = 3'd2;
    localparam logic [COND_W-1:0] COND_WHOLE  = 3'd3;
    localparam logic [COND_W-1:0] COND_MORE   = 3'd4;
    localparam logic [COND_W-1:0] COND_NOFRAC = 3'd5;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LOAD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MINUS = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DINIT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DSTEP = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PUSH  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_POP   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_POINT = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FRAC  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SPACE = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_SPACE;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            en;
    } ctrl_t;

    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] glyph;
        logic              last;
        logic              whole_nz;
        logic              frac_nz;
        logic              cnt_nz;
        logic              sp_last;
    } stat_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t uw;
        case (step)
            STEP_LOAD:  uw = '{op: OP_LOAD,  cond: COND_NONE,   target: STEP_LOAD};
            STEP_MINUS: uw = '{op: OP_MINUS, cond: COND_NONE,   target: STEP_LOAD};
            STEP_DINIT: uw = '{op: OP_DINIT, cond: COND_NONE,   target: STEP_LOAD};
            STEP_DSTEP: uw = '{op: OP_DSTEP, cond: COND_CNT,    target: STEP_DSTEP};
            STEP_PUSH:  uw = '{op: OP_PUSH,  cond: COND_WHOLE,  target: STEP_DINIT};
            STEP_POP:   uw = '{op: OP_POP,   cond: COND_MORE,   target: STEP_POP};
            STEP_POINT: uw = '{op: OP_POINT, cond: COND_NOFRAC, target: STEP_SPACE};
            STEP_FRAC:  uw = '{op: OP_FRAC,  cond: COND_CNT,    target: STEP_FRAC};
            STEP_SPACE: uw = '{op: OP_SPACE, cond: COND_ALWAYS, target: STEP_LOAD};
            default:    uw = '{op: OP_NOP,   cond: COND_ALWAYS, target: STEP_LOAD};
        endcase
        return uw;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
            c = ASCII_ZERO + CHAR_W'(d);
        else
            c = ASCII_A + CHAR_W'(d) - CHAR_W'(10);
        return c;
    endfunction

    function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN)
            r = BASE_MIN;
        else if (b > BASE_MAX)
            r = BASE_MAX;
        else
            r = b;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/vrd_datapath.sv
// Datapath: operand registers, bit-serial divider, digit stack and fraction multiplier.
`default_nettype none

module vrd_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire vrd_pkg::ctrl_t                  ctrl,
    input  wire logic                            is_negative,
    input  wire logic [vrd_pkg::WHOLE_BITS-1:0]  whole_part,
    input  wire logic [vrd_pkg::FRAC_BITS-1:0]   fraction_part,
    input  wire logic [vrd_pkg::BASE_W-1:0]      base_cfg,
    output vrd_pkg::stat_t                       stat
);

    logic                               neg_reg,   neg_next;
    logic [vrd_pkg::WHOLE_BITS-1:0]     whole_reg, whole_next;
    logic [vrd_pkg::FRAC_BITS-1:0]      frac_reg,  frac_next;
    logic [vrd_pkg::BASE_W-1:0]         b_reg,     b_next;
    logic [vrd_pkg::DIGIT_W-1:0]        rem_reg,   rem_next;
    logic [vrd_pkg::CNT_W-1:0]          cnt_reg,   cnt_next;
    logic [vrd_pkg::SP_W-1:0]           sp_reg,    sp_next;
    logic [vrd_pkg::DIGIT_W-1:0]        stack_reg [vrd_pkg::STACK_DEPTH];

    logic [vrd_pkg::BASE_W-1:0]         trial;
    logic                               qbit;
    logic [vrd_pkg::PROD_W-1:0]         prod;
    logic [vrd_pkg::SP_W-1:0]           sp_dec;
    logic [vrd_pkg::DIGIT_W-1:0]        top_digit;
    logic                               push_en;

    assign trial     = {rem_reg, whole_reg[vrd_pkg::WHOLE_BITS-1]};
    assign qbit      = (trial >= b_reg);
    assign prod      = vrd_pkg::PROD_W'(frac_reg) * vrd_pkg::PROD_W'(b_reg);
    assign sp_dec    = sp_reg - vrd_pkg::SP_W'(1);
    assign top_digit = stack_reg[sp_dec[vrd_pkg::IDX_W-1:0]];
    assign push_en   = ctrl.en && (ctrl.op == vrd_pkg::OP_PUSH);

    always_comb
    begin
        neg_next   = neg_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sp_next    = sp_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                vrd_pkg::OP_LOAD:
                begin
                    neg_next   = is_negative;
                    whole_next = whole_part;
                    frac_next  = fraction_part;
                    b_next     = vrd_pkg::sat_base(base_cfg);
                    sp_next    = '0;
                end
                vrd_pkg::OP_DINIT:
                begin
                    rem_next = '0;
                    cnt_next = vrd_pkg::CNT_W'(vrd_pkg::WHOLE_BITS - 1);
                end
                vrd_pkg::OP_DSTEP:
                begin
                    rem_next   = qbit ? vrd_pkg::DIGIT_W'(trial - b_reg)
                                      : vrd_pkg::DIGIT_W'(trial);
                    whole_next = {whole_reg[vrd_pkg::WHOLE_BITS-2:0], qbit};
                    cnt_next   = cnt_reg - vrd_pkg::CNT_W'(1);
                end
                vrd_pkg::OP_PUSH:
                    sp_next = sp_reg + vrd_pkg::SP_W'(1);
                vrd_pkg::OP_POP:
                    sp_next = sp_dec;
                vrd_pkg::OP_POINT:
                    cnt_next = vrd_pkg::CNT_W'(vrd_pkg::FRAC_DIGITS - 1);
                vrd_pkg::OP_FRAC:
                begin
                    frac_next = prod[vrd_pkg::FRAC_BITS-1:0];
                    cnt_next  = cnt_reg - vrd_pkg::CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else
            sp_reg <= sp_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        whole_reg <= whole_next;
        frac_reg  <= frac_next;
        b_reg     <= b_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_reg[sp_reg[vrd_pkg::IDX_W-1:0]] <= rem_reg;
    end

    always_comb
    begin
        stat.emit     = 1'b0;
        stat.glyph    = vrd_pkg::ASCII_SPACE;
        stat.last     = 1'b0;
        stat.whole_nz = (whole_reg != '0);
        stat.frac_nz  = (frac_reg != '0);
        stat.cnt_nz   = (cnt_reg != '0);
        stat.sp_last  = (sp_reg == vrd_pkg::SP_W'(1));
        case (ctrl.op)
            vrd_pkg::OP_MINUS:
            begin
                stat.emit  = neg_reg && ((whole_reg != '0) || (frac_reg != '0));
                stat.glyph = vrd_pkg::ASCII_MINUS;
            end
            vrd_pkg::OP_POP:
            begin
                stat.emit  = 1'b1;
                stat.glyph = vrd_pkg::glyph(top_digit);
            end
            vrd_pkg::OP_POINT:
            begin
                stat.emit  = (frac_reg != '0);
                stat.glyph = vrd_pkg::ASCII_POINT;
            end
            vrd_pkg::OP_FRAC:
            begin
                stat.emit  = 1'b1;
                stat.glyph = vrd_pkg::glyph(
                    prod[vrd_pkg::FRAC_BITS+vrd_pkg::DIGIT_W-1:vrd_pkg::FRAC_BITS]);
            end
            vrd_pkg::OP_SPACE:
            begin
                stat.emit  = 1'b1;
                stat.glyph = vrd_pkg::ASCII_SPACE;
                stat.last  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/value_to_radix_digits_core.sv
// Top level: microcode sequencer, output word register and base register port.
//
//  channel | handshake                         | payload
//  --------+-----------------------------------+---------------------------------------
//  in      | in_valid / in_ready               | is_negative, whole_part, fraction_part
//  out     | out_valid / out_ready             | character, last
//  cfg     | psel, penable, pwrite, pready     | paddr, pwdata, prdata (base at 0x0)
//
//  Each integer digit takes one setup, the one-bit-per-cycle restoring divider over all
//  whole bits, one push and one pop; fraction digits, produced only when the fraction
//  is nonzero, take one multiply each. Output stalls lengthen a number's run.
//  in_ready is high only in the load step.
//  Reset clears the step counter, output valid and sets base to ten.
//  A stalled output word holds the sequencer on its emitting step.
`default_nettype none

module value_to_radix_digits_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  is_negative,
    input  wire logic [vrd_pkg::WHOLE_BITS-1:0]        whole_part,
    input  wire logic [vrd_pkg::FRAC_BITS-1:0]         fraction_part,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [vrd_pkg::CHAR_W-1:0]                 character,
    output logic                                       last,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [vrd_pkg::PADDR_W-1:0]           paddr,
    input  wire logic [vrd_pkg::PDATA_W-1:0]           pwdata,
    output logic [vrd_pkg::PDATA_W-1:0]                prdata,
    output logic                                       pready
);

    logic [vrd_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [vrd_pkg::BASE_W-1:0]  base_reg, base_next;
    logic                        out_valid_reg, out_valid_next;
    logic [vrd_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;

    vrd_pkg::uword_t uw;
    vrd_pkg::ctrl_t  ctrl;
    vrd_pkg::stat_t  stat;
    logic            stall;
    logic            taken;
    logic            emit_fire;
    logic            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == vrd_pkg::REG_BASE);
    assign prdata    = (paddr[2] == vrd_pkg::REG_BASE) ? vrd_pkg::PDATA_W'(base_reg) : '0;
    assign base_next = cfg_write ? pwdata[vrd_pkg::BASE_W-1:0] : base_reg;

    assign uw        = vrd_pkg::ucode(step_reg);
    assign stall     = (stat.emit && out_valid_reg && !out_ready)
                    || ((uw.op == vrd_pkg::OP_LOAD) && !in_valid);
    assign ctrl.op   = uw.op;
    assign ctrl.en   = !stall;
    assign emit_fire = stat.emit && !stall;
    assign in_ready  = (step_reg == vrd_pkg::STEP_LOAD);

    vrd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .is_negative   (is_negative),
        .whole_part    (whole_part),
        .fraction_part (fraction_part),
        .base_cfg      (base_reg),
        .stat          (stat)
    );

    always_comb
    begin
        case (uw.cond)
            vrd_pkg::COND_ALWAYS: taken = 1'b1;
            vrd_pkg::COND_CNT:    taken = stat.cnt_nz;
            vrd_pkg::COND_WHOLE:  taken = stat.whole_nz;
            vrd_pkg::COND_MORE:   taken = !stat.sp_last;
            vrd_pkg::COND_NOFRAC: taken = !stat.frac_nz;
            default:              taken = 1'b0;
        endcase
        if (stall)
            step_next = step_reg;
        else if (taken)
            step_next = uw.target;
        else
            step_next = step_reg + vrd_pkg::STEP_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            char_next      = stat.glyph;
            last_next      = stat.last;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= vrd_pkg::STEP_LOAD;
            base_reg      <= vrd_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= vrd_pkg::STEP_LAST)
        else $error("step counter left the program");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == vrd_pkg::STEP_MINUS))
        else $error("accepted number did not start a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && stat.last) |=> (step_reg == vrd_pkg::STEP_LOAD) && out_valid_reg && last_reg)
        else $error("separator did not close the run");

endmodule

`default_nettype wire
